FILE: rtl/mcmp_pkg.sv
// Shared types and constants for the multi-channel motor PWM core.
// No dependencies; every other file in rtl/ imports this package.
package mcmp_pkg;

   typedef enum logic {
      MODE_TICK = 1'b0,
      MODE_SET  = 1'b1
   } mode_type;

   typedef logic        [1:0] chan_type;
   typedef logic signed [7:0] cmd_type;
   typedef logic        [7:0] drive_type;

   localparam int STEP_W     = 12;
   localparam int ACTIVE_W   = 3;
   localparam int CSR_DATA_W = 12;
   localparam int CSR_IDX_W  = 1;
   localparam int THRESH_W   = 16;
   localparam int MAG_W      = 7;
   localparam int CMD_LIMIT  = 100;

   typedef logic [STEP_W-1:0]     step_type;
   typedef logic [ACTIVE_W-1:0]   active_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;
   typedef logic [THRESH_W-1:0]   thresh_type;

   localparam csr_idx_type CSR_STEP_TICKS = 1'b0;
   localparam csr_idx_type CSR_ACTIVE_CH  = 1'b1;

   localparam step_type   STEP_RESET   = 12'd200;
   localparam active_type ACTIVE_RESET = 3'd2;
   localparam drive_type  DRIVE_RESET  = 8'hAA;

   localparam cmd_type CMD_MAX = 8'sd100;
   localparam cmd_type CMD_MIN = -8'sd100;

   // Clip a product to the 16-bit counter range.
   function automatic thresh_type sat16(input logic [31:0] value);
      thresh_type result;
      if (value > 32'h0000_FFFF) begin
         result = 16'hFFFF;
      end else begin
         result = value[THRESH_W-1:0];
      end
      return result;
   endfunction

endpackage

FILE: rtl/mcmp_if.sv
// Valid/ready channel interfaces for the motor PWM core: request and response.
// Depends on mcmp_pkg for the payload types.
interface mcmp_req_if import mcmp_pkg::*; ();
   logic     valid;
   logic     ready;
   mode_type mode;
   chan_type channel;
   cmd_type  power_command;

   modport source (output valid, output mode, output channel, output power_command,
                   input ready);
   modport sink   (input valid, input mode, input channel, input power_command,
                   output ready);
endinterface

interface mcmp_rsp_if import mcmp_pkg::*; ();
   logic      valid;
   logic      ready;
   drive_type drive_byte;

   modport source (output valid, output drive_byte, input ready);
   modport sink   (input valid, input drive_byte, output ready);
endinterface

FILE: rtl/mcmp_quant.sv
// Power command quantizer: clamp to +/-100, take the magnitude, divide into levels.
// Depends on mcmp_pkg. Division by the constant step uses a reciprocal multiply.
module mcmp_quant import mcmp_pkg::*; #(
   parameter  int POWER_STEPS = 20,
   localparam int LEVEL_W     = $clog2(POWER_STEPS + 1)
) (
   input  cmd_type              power_command,
   output logic [LEVEL_W-1:0]   level,
   output logic                 forward
);

   localparam int QUANT       = CMD_LIMIT / POWER_STEPS;
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP_W     = 17;
   localparam int RECIP       = ((1 << RECIP_SHIFT) + QUANT - 1) / QUANT;
   localparam int PROD_W      = MAG_W + RECIP_W;

   cmd_type                clamped;
   logic [MAG_W-1:0]       mag;
   logic [PROD_W-1:0]      prod;
   logic [MAG_W-1:0]       quot;

   always_comb begin
      if (power_command > CMD_MAX) begin
         clamped = CMD_MAX;
      end else if (power_command < CMD_MIN) begin
         clamped = CMD_MIN;
      end else begin
         clamped = power_command;
      end
      mag  = clamped[7] ? MAG_W'(-clamped) : MAG_W'(clamped);
      // Rounded-up reciprocal: error stays far below one quotient step for mag <= 100.
      prod = PROD_W'(mag) * PROD_W'(RECIP);
      quot = MAG_W'(prod >> RECIP_SHIFT);
      if (quot > MAG_W'(POWER_STEPS)) begin
         level = LEVEL_W'(POWER_STEPS);
      end else begin
         level = LEVEL_W'(quot);
      end
      forward = ~clamped[7];
   end

endmodule

FILE: rtl/multi_channel_motor_pwm_core.sv
// Multi-channel motor PWM core: set and tick items update levels and phase.
// A request beat loads the input register; when the response side can take the item,
// it then loads the drive register and raises the response valid. Throughput is one
// item per cycle unless responses stall, set by the single update stage between the two registers.
// Reset (synchronous, active high): levels, thresholds and phase clear, drive
// byte 0xAA, step_ticks 200, active_channels 2.
module multi_channel_motor_pwm_core import mcmp_pkg::*; #(
   parameter int CHANNELS    = 4,
   parameter int POWER_STEPS = 20
) (
   input  logic         clock,
   input  logic         reset,
   mcmp_req_if.sink     req_bus,
   mcmp_rsp_if.source   rsp_bus,
   input  logic         csr_write_en,
   input  csr_idx_type  csr_index,
   input  csr_data_type csr_write_data
);

   localparam int LEVEL_W = $clog2(POWER_STEPS + 1);
   localparam int PROD_W  = LEVEL_W + STEP_W;

   // Configuration registers
   step_type   step_ff;
   active_type active_ff;

   // Input register stage
   logic               s1_valid_ff;
   mode_type           s1_mode_ff;
   chan_type           s1_chan_ff;
   logic [LEVEL_W-1:0] s1_level_ff;
   logic               s1_fwd_ff;

   logic [LEVEL_W-1:0] q_level;
   logic               q_fwd;

   // Channel state and drive register
   logic [LEVEL_W-1:0] level_ff  [CHANNELS];
   logic [LEVEL_W-1:0] level_in  [CHANNELS];
   thresh_type         thresh_ff [CHANNELS];
   thresh_type         thresh_in [CHANNELS];
   thresh_type         phase_ff;
   thresh_type         phase_in;
   drive_type          drive_ff;
   drive_type          drive_in;
   logic               rsp_valid_ff;

   logic               advance;
   logic               set_hit;
   step_type           step_len;
   thresh_type         period;
   thresh_type         new_thresh;
   logic [THRESH_W:0]  phase_next;
   logic               chan_on;

   mcmp_quant #(
      .POWER_STEPS (POWER_STEPS)
   ) u_quant (
      .power_command (req_bus.power_command),
      .level         (q_level),
      .forward       (q_fwd)
   );

   assign advance       = s1_valid_ff & (~rsp_valid_ff | rsp_bus.ready);
   assign req_bus.ready = ~s1_valid_ff | advance;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.drive_byte = drive_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= STEP_RESET;
         active_ff <= ACTIVE_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_STEP_TICKS: step_ff   <= csr_write_data[STEP_W-1:0];
            CSR_ACTIVE_CH:  active_ff <= csr_write_data[ACTIVE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         s1_valid_ff <= req_bus.valid;
      end
      if (req_bus.valid && req_bus.ready) begin
         s1_mode_ff  <= req_bus.mode;
         s1_chan_ff  <= req_bus.channel;
         s1_level_ff <= q_level;
         s1_fwd_ff   <= q_fwd;
      end
   end

   always_comb begin
      step_len   = (step_ff == '0) ? STEP_W'(1) : step_ff;
      period     = sat16(32'(PROD_W'(POWER_STEPS) * PROD_W'(step_len)));
      new_thresh = sat16(32'(PROD_W'(s1_level_ff) * PROD_W'(step_len)));
      set_hit    = (s1_mode_ff == MODE_SET) && ({1'b0, s1_chan_ff} < 3'(CHANNELS));
      phase_next = {1'b0, phase_ff} + 17'd1;

      if (set_hit) begin
         phase_in = '0;
      end else if (s1_mode_ff == MODE_TICK) begin
         // Wrap at the period end, also when the period shrank below the phase.
         phase_in = (phase_next >= {1'b0, period}) ? '0 : phase_next[THRESH_W-1:0];
      end else begin
         phase_in = phase_ff;
      end

      drive_in = drive_ff;
      for (int i = 0; i < CHANNELS; i++) begin
         level_in[i]  = level_ff[i];
         thresh_in[i] = thresh_ff[i];
         if (set_hit && (s1_chan_ff == 2'(i))) begin
            level_in[i]       = s1_level_ff;
            thresh_in[i]      = new_thresh;
            drive_in[2*i + 1] = s1_fwd_ff;
         end
         // After a set the phase is zero, so any nonzero level is on.
         chan_on = (level_in[i] != '0) &&
                   (set_hit || (level_in[i] >= LEVEL_W'(POWER_STEPS)) ||
                    (phase_in < thresh_ff[i]));
         if (3'(i) < active_ff) begin
            drive_in[2*i] = chan_on;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= '0;
         drive_ff     <= DRIVE_RESET;
         for (int i = 0; i < CHANNELS; i++) begin
            level_ff[i]  <= '0;
            thresh_ff[i] <= '0;
         end
      end else begin
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            phase_ff     <= phase_in;
            drive_ff     <= drive_in;
            for (int i = 0; i < CHANNELS; i++) begin
               level_ff[i]  <= level_in[i];
               thresh_ff[i] <= thresh_in[i];
            end
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

FILE: dv/multi_channel_motor_pwm_core_test.sv
// Self-checking testbench for multi_channel_motor_pwm_core: set and tick beats
// scored against a cycle-free model of the drive byte.
// Depends on mcmp_pkg and the mcmp_req_if / mcmp_rsp_if interfaces.
module multi_channel_motor_pwm_core_test;
   import mcmp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_MOTORS   = 4;
   localparam int PWM_LEVELS   = 20;
   localparam int STALL_LIMIT  = 4000;
   localparam int REPORT_LIMIT = 10;
   localparam int HOLD_AT_BEAT = 700;
   localparam int HOLD_CYCLES  = 90;

   typedef struct packed {
      mode_type mode;
      chan_type channel;
      cmd_type  cmd;
   } pwm_item_type;

   logic         clock;
   logic         reset;
   logic         csr_write_en;
   csr_idx_type  csr_index;
   csr_data_type csr_write_data;

   mcmp_req_if req_bus ();
   mcmp_rsp_if rsp_bus ();

   multi_channel_motor_pwm_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // Model state
   step_type   cfg_step;
   active_type cfg_active;
   logic [4:0] motor_level [NUM_MOTORS];
   thresh_type motor_thresh [NUM_MOTORS];
   thresh_type phase_cnt;
   drive_type  drive_state;

   pwm_item_type pending_items[$];
   drive_type    expected_drive_q[$];
   int           mismatch_count;
   int           rsp_beats;
   int           idle_cycles;
   pwm_item_type seen_beat;

   // Sender and receiver pacing
   pwm_item_type next_beat;
   int           burst_left;
   int           gap_left;
   int           hold_left;
   bit           hold_done;
   int           pattern_sel;
   int           pattern_cycles;

   function automatic drive_type compute_drive_byte(input pwm_item_type it);
      int cmd_val;
      int magnitude;
      int level;
      int step_eff;
      int period;
      int product;
      int lanes;
      int idx;
      bit on;
      step_eff = (cfg_step == 0) ? 1 : int'(cfg_step);
      if (it.mode == MODE_SET) begin
         cmd_val = it.cmd;
         if (cmd_val > CMD_LIMIT) cmd_val = CMD_LIMIT;
         if (cmd_val < -CMD_LIMIT) cmd_val = -CMD_LIMIT;
         magnitude = (cmd_val < 0) ? -cmd_val : cmd_val;
         level = magnitude / (CMD_LIMIT / PWM_LEVELS);
         if (level > PWM_LEVELS) level = PWM_LEVELS;
         product = level * step_eff;
         motor_level[it.channel] = level[4:0];
         motor_thresh[it.channel] = (product > 'hFFFF) ? 16'hFFFF : product[15:0];
         drive_state[2 * it.channel + 1] = (cmd_val >= 0);
         phase_cnt = '0;
      end else begin
         period = PWM_LEVELS * step_eff;
         if (period > 'hFFFF) period = 'hFFFF;
         // wrap also covers a phase left beyond a freshly shortened period
         if (int'(phase_cnt) + 1 >= period) phase_cnt = '0;
         else phase_cnt = phase_cnt + 1'b1;
      end
      lanes = (cfg_active > NUM_MOTORS) ? NUM_MOTORS : int'(cfg_active);
      for (idx = 0; idx < lanes; idx++) begin
         if (motor_level[idx] == 0) on = 1'b0;
         else if (motor_level[idx] >= PWM_LEVELS) on = 1'b1;
         else on = (phase_cnt < motor_thresh[idx]);
         drive_state[2 * idx] = on;
      end
      return drive_state;
   endfunction

   task automatic push_item(input mode_type mode, input int channel, input int cmd);
      pwm_item_type it;
      it.mode = mode;
      it.channel = chan_type'(channel);
      it.cmd = cmd_type'(cmd);
      pending_items.push_back(it);
   endtask

   task automatic add_random_items(input int count, input int set_pct, input int tail_ticks);
      pwm_item_type it;
      int n;
      // lead with ticks so a stale phase meets the new period first
      for (n = 0; n < 3; n++) push_item(MODE_TICK, $urandom_range(0, 3), $urandom_range(0, 255));
      for (n = 0; n < count; n++) begin
         it.mode = ($urandom_range(0, 99) < set_pct) ? MODE_SET : MODE_TICK;
         it.channel = chan_type'($urandom_range(0, 3));
         case ($urandom_range(0, 3))
            0, 1: it.cmd = cmd_type'($urandom_range(0, 255));
            2: it.cmd = cmd_type'(5 * $urandom_range(0, 40) - 100 + $urandom_range(0, 2) - 1);
            default: begin
               case ($urandom_range(0, 7))
                  0: it.cmd = 8'sd0;
                  1: it.cmd = -8'sd1;
                  2: it.cmd = CMD_MAX;
                  3: it.cmd = CMD_MIN;
                  4: it.cmd = 8'sd127;
                  5: it.cmd = -8'sd128;
                  6: it.cmd = 8'sd101;
                  default: it.cmd = -8'sd101;
               endcase
            end
         endcase
         pending_items.push_back(it);
      end
      for (n = 0; n < tail_ticks; n++) push_item(MODE_TICK, $urandom_range(0, 3), $urandom_range(0, 255));
   endtask

   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pending_items.size() != 0 || req_bus.valid || expected_drive_q.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic program_regs(input int step, input int active);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_STEP_TICKS;
      csr_write_data <= csr_data_type'(step);
      @(posedge clock);
      csr_index      <= CSR_ACTIVE_CH;
      csr_write_data <= csr_data_type'(active);
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   task automatic run_phase(input int step, input int active, input int count,
                            input int set_pct, input int tail_ticks);
      program_regs(step, active);
      add_random_items(count, set_pct, tail_ticks);
      wait_drained();
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      reset                 = 1'b1;
      csr_write_en          = 1'b0;
      csr_index             = CSR_STEP_TICKS;
      csr_write_data        = '0;
      req_bus.valid         = 1'b0;
      req_bus.mode          = MODE_TICK;
      req_bus.channel       = '0;
      req_bus.power_command = '0;
      rsp_bus.ready         = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, clamping, level edges, both directions
      program_regs(1, 4);
      push_item(MODE_SET, 0, 127);
      push_item(MODE_SET, 1, -128);
      push_item(MODE_SET, 2, 100);
      push_item(MODE_SET, 3, -100);
      push_item(MODE_TICK, 0, 0);
      push_item(MODE_TICK, 3, -1);
      push_item(MODE_SET, 0, 0);
      push_item(MODE_SET, 1, 4);
      push_item(MODE_SET, 2, 5);
      push_item(MODE_SET, 3, -99);
      repeat (6) push_item(MODE_TICK, 1, 85);
      push_item(MODE_SET, 1, -1);
      push_item(MODE_SET, 2, 101);
      push_item(MODE_SET, 3, -101);
      push_item(MODE_SET, 0, 50);
      repeat (4) push_item(MODE_TICK, 2, 42);
      wait_drained();

      add_random_items(200, 20, 0);
      wait_drained();
      run_phase(0, 4, 180, 15, 0);
      run_phase(4095, 7, 100, 30, 0);
      run_phase(3276, 1, 90, 30, 0);
      run_phase(10, 3, 130, 15, 160);
      run_phase(2, 0, 170, 15, 0);
      run_phase(5, 5, 220, 10, 0);
      run_phase(3, 2, 220, 10, 0);
      run_phase(1, 6, 170, 25, 0);
      run_phase(4, 4, 130, 10, 0);

      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && expected_drive_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Request driver: bursts of beats separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left    <= 1;
         gap_left      <= 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (gap_left != 0) begin
            gap_left      <= gap_left - 1;
            req_bus.valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            next_beat = pending_items.pop_front();
            req_bus.valid         <= 1'b1;
            req_bus.mode          <= next_beat.mode;
            req_bus.channel       <= next_beat.channel;
            req_bus.power_command <= next_beat.cmd;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Response receiver: rotating stall patterns plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready  <= 1'b0;
         hold_left      <= 0;
         hold_done      <= 1'b0;
         pattern_sel    <= 0;
         pattern_cycles <= 0;
      end else if (hold_left != 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (!hold_done && rsp_beats >= HOLD_AT_BEAT) begin
         hold_left     <= HOLD_CYCLES;
         hold_done     <= 1'b1;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (pattern_cycles == 0) begin
            pattern_sel    <= $urandom_range(0, 3);
            pattern_cycles <= $urandom_range(16, 96);
         end else begin
            pattern_cycles <= pattern_cycles - 1;
         end
         case (pattern_sel)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_bus.ready <= $urandom_range(0, 1);
            default: rsp_bus.ready <= (pattern_cycles % 4 == 0);
         endcase
      end
   end

   // Scoreboard: predict on request beats, compare on response beats
   always @(posedge clock) begin
      if (reset) begin
         cfg_step    = STEP_RESET;
         cfg_active  = ACTIVE_RESET;
         phase_cnt   = '0;
         drive_state = DRIVE_RESET;
         for (int i = 0; i < NUM_MOTORS; i++) begin
            motor_level[i]  = '0;
            motor_thresh[i] = '0;
         end
         mismatch_count = 0;
         rsp_beats      = 0;
      end else begin
         if (csr_write_en) begin
            if (csr_index == CSR_STEP_TICKS) cfg_step = csr_write_data[STEP_W-1:0];
            else cfg_active = csr_write_data[ACTIVE_W-1:0];
         end
         if (req_bus.valid && req_bus.ready) begin
            seen_beat.mode    = req_bus.mode;
            seen_beat.channel = req_bus.channel;
            seen_beat.cmd     = req_bus.power_command;
            expected_drive_q.push_back(compute_drive_byte(seen_beat));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_beats = rsp_beats + 1;
            if (expected_drive_q.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("response beat with no prediction: drive_byte %02h",
                           rsp_bus.drive_byte);
            end else if (rsp_bus.drive_byte !== expected_drive_q[0]) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("drive_byte wrong at beat %0d: expected %02h, got %02h",
                           rsp_beats, expected_drive_q[0], rsp_bus.drive_byte);
               void'(expected_drive_q.pop_front());
            end else begin
               void'(expected_drive_q.pop_front());
            end
         end
      end
   end

   // Watchdog: give up after a long stretch with no beat of any kind
   always @(posedge clock) begin
      if (reset || csr_write_en || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

FILE: files.f
rtl/mcmp_pkg.sv
rtl/mcmp_if.sv
rtl/mcmp_quant.sv
rtl/multi_channel_motor_pwm_core.sv
dv/multi_channel_motor_pwm_core_test.sv
